[rtl/wtol_pkg.sv]
`default_nettype none

package wtol_pkg;

  // table, phase and sample geometry
  localparam int TABLE_ADDR_BITS = 11;
  localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
  localparam int FRAC_BITS       = 16;
  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_BITS      = TABLE_ADDR_BITS + FRAC_BITS;
  localparam int INC_BITS        = PHASE_BITS;

  // output level, unsigned with LEVEL_FRAC_BITS fraction bits
  localparam int GAIN_BITS       = 17;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam logic [GAIN_BITS-1:0] LEVEL_RESET = GAIN_BITS'(1 << LEVEL_FRAC_BITS);

  // datapath widths
  localparam int LERP_PROD_BITS = FRAC_BITS + SAMPLE_BITS + 2;
  localparam int GAIN_PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SCALED_BITS    = GAIN_PROD_BITS - LEVEL_FRAC_BITS;
  localparam int SUM_BITS       = SCALED_BITS + 1;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // input kinds
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_STOP   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // configuration registers
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_GAIN      = 1'b1;

  // command queue between front and back
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]                    func;
    logic [TABLE_ADDR_BITS-1:0]    addr;
    logic signed [SAMPLE_BITS-1:0] value;
    logic signed [SAMPLE_BITS-1:0] mix;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/wtol_ram.sv]
`default_nettype none

module wtol_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

[rtl/wtol_front.sv]
`default_nettype none

module wtol_front (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       push,
  output logic                                       full,
  input  logic [1:0]                                 func,
  input  logic [wtol_pkg::TABLE_ADDR_BITS-1:0]       table_addr,
  input  logic signed [wtol_pkg::SAMPLE_BITS-1:0]    table_value,
  input  logic signed [wtol_pkg::SAMPLE_BITS-1:0]    mix_in,
  output logic                                       cmd_valid,
  output wtol_pkg::cmd_t                             cmd,
  input  logic                                       cmd_pop
);

  import wtol_pkg::*;

  cmd_t                      queue [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      enq;
  logic                      deq;

  // accepted beats of the unused kind are dropped here
  assign full      = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign enq       = push && !full && (func != FUNC_UNUSED);
  assign deq       = cmd_pop && cmd_valid;

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue entries
  always_ff @(posedge clk) begin
    if (enq) begin
      queue[wr_ptr] <= '{func: func, addr: table_addr, value: table_value, mix: mix_in};
    end
  end

endmodule

`default_nettype wire

[rtl/wtol_back.sv]
`default_nettype none

module wtol_back (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cmd_valid,
  input  wtol_pkg::cmd_t                           cmd,
  output logic                                     cmd_pop,
  input  logic                                     cfg_we,
  input  logic [wtol_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [wtol_pkg::INC_BITS-1:0]            cfg_data,
  output logic                                     empty,
  input  logic                                     pop,
  output logic signed [wtol_pkg::SAMPLE_BITS-1:0]  mix_out
);

  import wtol_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LERP = 3'd2;
  localparam logic [2:0] ST_GAIN = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;

  logic [2:0]                    state;
  logic [PHASE_BITS-1:0]         phase;
  logic [INC_BITS-1:0]           phase_increment;
  logic [GAIN_BITS-1:0]          level_gain;
  logic                          out_valid;

  logic [FRAC_BITS-1:0]          frac;
  logic signed [SAMPLE_BITS-1:0] mix_hold;
  logic signed [SAMPLE_BITS-1:0] v0_hold;
  logic signed [LERP_PROD_BITS-1:0] lerp_prod;
  logic signed [SAMPLE_BITS-1:0] interp;
  logic signed [SCALED_BITS-1:0] scaled;

  logic                          out_free;
  logic                          ram_we;
  logic                          ram_re;
  logic [TABLE_ADDR_BITS-1:0]    idx0;
  logic [TABLE_ADDR_BITS-1:0]    idx1;
  logic [SAMPLE_BITS-1:0]        ram_a;
  logic [SAMPLE_BITS-1:0]        ram_b;
  logic                          inc_zero;
  logic                          tick_start;
  logic                          bypass_load;
  logic                          sat_load;

  logic signed [SAMPLE_BITS:0]      diff;
  logic signed [LERP_PROD_BITS-1:0] lerp_full;
  logic signed [SAMPLE_BITS+1:0]    lerp_shift;
  logic signed [SAMPLE_BITS+1:0]    interp_sum;
  logic signed [GAIN_PROD_BITS-1:0] gain_full;
  logic signed [SUM_BITS-1:0]       sum;
  logic                             overflow;
  logic [SAMPLE_BITS-1:0]           sat;

  // table addresses from the current phase, upper neighbor wraps
  assign idx0 = phase[PHASE_BITS-1:FRAC_BITS];
  assign idx1 = idx0 + 1'b1;

  wtol_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk       (clk),
    .we        (ram_we),
    .wr_addr   (cmd.addr),
    .wr_data   (cmd.value),
    .re        (ram_re),
    .rd_addr_a (idx0),
    .rd_addr_b (idx1),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  // command dispatch in idle
  always_comb begin
    out_free    = !out_valid || pop;
    inc_zero    = (phase_increment == '0);
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    tick_start  = 1'b0;
    bypass_load = 1'b0;
    if (state == ST_IDLE && cmd_valid) begin
      case (cmd.func)
        FUNC_WRITE: begin
          cmd_pop = 1'b1;
          ram_we  = 1'b1;
        end
        FUNC_STOP: begin
          cmd_pop = 1'b1;
        end
        FUNC_TICK: begin
          if (!inc_zero) begin
            cmd_pop    = 1'b1;
            ram_re     = 1'b1;
            tick_start = 1'b1;
          end else if (out_free) begin
            cmd_pop     = 1'b1;
            bypass_load = 1'b1;
          end
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
    sat_load = (state == ST_SAT) && out_free;
  end

  // interpolation, gain and saturation arithmetic
  always_comb begin
    diff       = $signed({ram_b[SAMPLE_BITS-1], ram_b}) - $signed({ram_a[SAMPLE_BITS-1], ram_a});
    lerp_full  = $signed({1'b0, frac}) * diff;
    lerp_shift = $signed(lerp_prod[LERP_PROD_BITS-1:FRAC_BITS]);
    interp_sum = $signed({{2{v0_hold[SAMPLE_BITS-1]}}, v0_hold}) + lerp_shift;
    gain_full  = interp * $signed({1'b0, level_gain});
    sum        = $signed({{(SUM_BITS-SAMPLE_BITS){mix_hold[SAMPLE_BITS-1]}}, mix_hold})
               + $signed({scaled[SCALED_BITS-1], scaled});
    overflow   = (sum[SUM_BITS-1:SAMPLE_BITS-1] != '0)
              && (sum[SUM_BITS-1:SAMPLE_BITS-1] != '1);
    if (overflow) begin
      sat = sum[SUM_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      sat = sum[SAMPLE_BITS-1:0];
    end
  end

  // sequencer, phase, configuration and result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase           <= '0;
      phase_increment <= '0;
      level_gain      <= LEVEL_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_INCREMENT: phase_increment <= cfg_data;
          REG_LEVEL_GAIN:      level_gain      <= cfg_data[GAIN_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_pop && cmd.func == FUNC_STOP) begin
        phase           <= '0;
        phase_increment <= '0;
      end
      if (tick_start) begin
        phase <= phase + phase_increment;
      end
      if (bypass_load || sat_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (tick_start) begin
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_LERP;
        ST_LERP: state <= ST_GAIN;
        ST_GAIN: state <= ST_SAT;
        ST_SAT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tick_start) begin
      frac     <= phase[FRAC_BITS-1:0];
      mix_hold <= cmd.mix;
    end
    if (state == ST_READ) begin
      v0_hold   <= $signed(ram_a);
      lerp_prod <= lerp_full;
    end
    if (state == ST_LERP) begin
      interp <= interp_sum[SAMPLE_BITS-1:0];
    end
    if (state == ST_GAIN) begin
      scaled <= gain_full[GAIN_PROD_BITS-1:LEVEL_FRAC_BITS];
    end
    if (bypass_load) begin
      mix_out <= cmd.mix;
    end else if (sat_load) begin
      mix_out <= $signed(sat);
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

[rtl/wavetable_oscillator_lerp.sv]
`default_nettype none

// Wavetable oscillator with linear interpolation. Beats enter through a
// two-entry command queue, one per cycle while full is low. The back end
// handles writes and stops from idle, returns mix_in unchanged for a tick
// with zero increment once the output register is free, and steps any other
// tick through table read on the dual-read RAM, interpolation multiply,
// interpolation add, gain multiply, add and saturate, taking no new command
// until that result is in the output register. A finished result waits in
// the output register until popped while the queue keeps filling. Table
// entries are not cleared at reset: read only entries that have been
// written. A stop clears both the phase and the phase_increment register.
module wavetable_oscillator_lerp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     full,
  input  logic [1:0]                               func,
  input  logic [wtol_pkg::TABLE_ADDR_BITS-1:0]     table_addr,
  input  logic signed [wtol_pkg::SAMPLE_BITS-1:0]  table_value,
  input  logic signed [wtol_pkg::SAMPLE_BITS-1:0]  mix_in,
  output logic                                     empty,
  input  logic                                     pop,
  output logic signed [wtol_pkg::SAMPLE_BITS-1:0]  mix_out,
  input  logic                                     cfg_we,
  input  logic [wtol_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [wtol_pkg::INC_BITS-1:0]            cfg_data
);

  import wtol_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // front end: accept and classify beats
  wtol_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .table_addr  (table_addr),
    .table_value (table_value),
    .mix_in      (mix_in),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // back end: table, phase, arithmetic and result slot
  wtol_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .mix_out   (mix_out)
  );

  // back end never pops an empty queue
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // a kept beat shows up in the queue next cycle
  a_enq_visible: assert property (@(posedge clk) disable iff (rst)
    (push && !full && func != FUNC_UNUSED) |=> cmd_valid)
    else $error("accepted beat missing from queue");

  // a result only leaves when popped
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    $rose(empty) |-> ($past(pop) || $past(rst)))
    else $error("result dropped without pop");

endmodule

`default_nettype wire

[tb/tb_wavetable_oscillator_lerp.sv]
`default_nettype none

module tb_wavetable_oscillator_lerp;
  timeunit 1ns;
  timeprecision 1ps;

  import wtol_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_BEATS   = 40;
  // entries written at each end of the table before any tick
  localparam int FILL_SPAN     = 56;

  localparam logic [INC_BITS-1:0]  INC_MAX  = '1;
  localparam logic [INC_BITS-1:0]  INC_ONE  = INC_BITS'(1 << FRAC_BITS);
  localparam logic [INC_BITS-1:0]  INC_LAST = INC_BITS'((TABLE_DEPTH - 1) << FRAC_BITS);
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;

  // one row of the directed plan: a register load or a beat
  typedef struct packed {
    logic                       cfg;
    logic [INC_BITS-1:0]        inc;
    logic [GAIN_BITS-1:0]       gain;
    logic [1:0]                 func;
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [SAMPLE_BITS-1:0]     value;
    logic [SAMPLE_BITS-1:0]     mix;
    logic                       chk;
    logic [SAMPLE_BITS-1:0]     want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] func = FUNC_TICK;
  logic [TABLE_ADDR_BITS-1:0] table_addr = '0;
  logic signed [SAMPLE_BITS-1:0] table_value = '0;
  logic signed [SAMPLE_BITS-1:0] mix_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SAMPLE_BITS-1:0] mix_out;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_PHASE_INCREMENT;
  logic [INC_BITS-1:0] cfg_data = '0;

  // typed-in expectation travelling with the beat
  logic drv_chk = 1'b0;
  logic [SAMPLE_BITS-1:0] drv_want = '0;

  // predictor state
  logic [PHASE_BITS-1:0] osc_phase;
  logic [INC_BITS-1:0] osc_inc;
  logic [GAIN_BITS-1:0] osc_gain;
  logic signed [SAMPLE_BITS-1:0] wave [TABLE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] mix_due [$];

  plan_row_t plan [$];
  bit no_idle = 1'b0;
  int stall_left = 0;
  int errors = 0;
  int cycles = 0;

  wavetable_oscillator_lerp DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .table_addr  (table_addr),
    .table_value (table_value),
    .mix_in      (mix_in),
    .empty       (empty),
    .pop         (pop),
    .mix_out     (mix_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic plan_row_t beat_row(input logic [1:0] f,
      input logic [TABLE_ADDR_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] v,
      input logic [SAMPLE_BITS-1:0] m, input logic chk, input logic [SAMPLE_BITS-1:0] want);
    plan_row_t row;
    row = '0;
    row.func = f;
    row.addr = a;
    row.value = v;
    row.mix = m;
    row.chk = chk;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [INC_BITS-1:0] inc,
      input logic [GAIN_BITS-1:0] gain);
    plan_row_t row;
    row = '0;
    row.cfg = 1'b1;
    row.inc = inc;
    row.gain = gain;
    return row;
  endfunction

  // one oscillator tick: interpolate, scale, mix, saturate, advance phase; zero increment passes mix through
  task automatic osc_tick(input logic signed [SAMPLE_BITS-1:0] mix,
      output logic signed [SAMPLE_BITS-1:0] res);
    logic [TABLE_ADDR_BITS-1:0] i0, i1;
    longint lo, hi, interp, scaled, sum, smax, smin;
    if (osc_inc == '0) begin
      res = mix;
      return;
    end
    i0 = osc_phase[PHASE_BITS-1:FRAC_BITS];
    i1 = i0 + 1'b1;
    lo = longint'(wave[i0]);
    hi = longint'(wave[i1]);
    interp = lo + ((longint'(osc_phase[FRAC_BITS-1:0]) * (hi - lo)) >>> FRAC_BITS);
    scaled = (interp * longint'(osc_gain)) >>> LEVEL_FRAC_BITS;
    sum = longint'(mix) + scaled;
    smax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    smin = -smax - 1;
    if (sum > smax) sum = smax;
    if (sum < smin) sum = smin;
    res = sum[SAMPLE_BITS-1:0];
    osc_phase = osc_phase + osc_inc;
  endtask

  // drive one input beat and hold it until accepted
  task automatic send_beat(input logic [1:0] f, input logic [TABLE_ADDR_BITS-1:0] a,
      input logic [SAMPLE_BITS-1:0] v, input logic [SAMPLE_BITS-1:0] m,
      input logic chk, input logic [SAMPLE_BITS-1:0] want);
    int gap;
    push <= 1'b1;
    func <= f;
    table_addr <= a;
    table_value <= v;
    mix_in <= m;
    drv_chk <= chk;
    drv_want <= want;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for all results, then let writes and stops finish
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (mix_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input logic [INC_BITS-1:0] inc, input logic [GAIN_BITS-1:0] gain);
    cfg_we <= 1'b1;
    cfg_index <= REG_PHASE_INCREMENT;
    cfg_data <= inc;
    @(posedge clk);
    cfg_index <= REG_LEVEL_GAIN;
    cfg_data <= INC_BITS'(gain);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if (!no_idle) stall_left = gap_len();
    end
  end

  // track accepted beats and check results
  always @(posedge clk) begin : monitor
    logic signed [SAMPLE_BITS-1:0] res;
    logic signed [SAMPLE_BITS-1:0] due;
    if (rst) begin
      osc_phase = '0;
      osc_inc = '0;
      osc_gain = LEVEL_RESET;
    end else begin
      if (pop && !empty) begin
        if (mix_due.size() == 0) begin
          flag_error($sformatf("unexpected result mix_out=%h", mix_out));
        end else begin
          due = mix_due.pop_front();
          if (mix_out !== due)
            flag_error($sformatf("mix_out got %h want %h", mix_out, due));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_INCREMENT: osc_inc = cfg_data;
          REG_LEVEL_GAIN: osc_gain = cfg_data[GAIN_BITS-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        case (func)
          FUNC_TICK: begin
            osc_tick(mix_in, res);
            mix_due.push_back(drv_chk ? drv_want : res);
          end
          FUNC_WRITE: wave[table_addr] = table_value;
          FUNC_STOP: begin
            osc_phase = '0;
            osc_inc = '0;
          end
          default: ;
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("wavetable_oscillator_lerp regression: fail");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    logic [1:0] f;
    logic [INC_BITS-1:0] inc;
    logic [GAIN_BITS-1:0] gain;
    int pick;

    // directed plan: passthrough after reset, ignored selector
    plan.push_back(beat_row(FUNC_TICK, '0, '0, 24'h123456, 1'b1, 24'h123456));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, SAMPLE_MAX, 1'b1, SAMPLE_MAX));
    plan.push_back(beat_row(FUNC_TICK, '1, '1, SAMPLE_MIN, 1'b1, SAMPLE_MIN));
    plan.push_back(beat_row(FUNC_UNUSED, '1, SAMPLE_MAX, SAMPLE_MAX, 1'b0, '0));
    // table extremes at both ends
    plan.push_back(beat_row(FUNC_WRITE, 11'd0, SAMPLE_MAX, '0, 1'b0, '0));
    plan.push_back(beat_row(FUNC_WRITE, 11'd1, SAMPLE_MAX, '0, 1'b0, '0));
    plan.push_back(beat_row(FUNC_WRITE, 11'd2, SAMPLE_MAX, '0, 1'b0, '0));
    plan.push_back(beat_row(FUNC_WRITE, '1, SAMPLE_MIN, '0, 1'b0, '0));
    // one entry per tick at unity, high saturation
    plan.push_back(cfg_row(INC_ONE, LEVEL_RESET));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, '0, 1'b1, SAMPLE_MAX));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, '0, 1'b1, SAMPLE_MAX));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, SAMPLE_MAX, 1'b1, SAMPLE_MAX));
    // stop clears the increment too
    plan.push_back(beat_row(FUNC_STOP, '0, '0, '0, 1'b0, '0));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, 24'h000005, 1'b1, 24'h000005));
    // jump to the last entry, low saturation
    plan.push_back(cfg_row(INC_LAST, LEVEL_RESET));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, '0, 1'b1, SAMPLE_MAX));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, SAMPLE_MIN, 1'b1, SAMPLE_MIN));
    plan.push_back(beat_row(FUNC_STOP, '1, '1, '1, 1'b0, '0));
    // largest increment, zero gain
    plan.push_back(cfg_row(INC_MAX, '0));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, 24'h000007, 1'b1, 24'h000007));
    // largest gain, last entry interpolating toward entry zero
    plan.push_back(cfg_row(INC_MAX, GAIN_MAX));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, 24'h0abcde, 1'b0, '0));
    plan.push_back(beat_row(FUNC_TICK, '0, '0, SAMPLE_MIN, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill both ends of the table; every phase below stays inside them
    no_idle = 1'b1;
    for (int a = 0; a < FILL_SPAN; a++) begin
      send_beat(FUNC_WRITE, TABLE_ADDR_BITS'(a), rand_sample(), SAMPLE_BITS'($urandom),
                1'b0, '0);
      send_beat(FUNC_WRITE, TABLE_ADDR_BITS'(TABLE_DEPTH - 1 - a), rand_sample(),
                SAMPLE_BITS'($urandom), 1'b0, '0);
    end
    no_idle = 1'b0;

    // directed plan
    foreach (plan[i]) begin
      row = plan[i];
      if (row.cfg) begin
        settle();
        load_regs(row.inc, row.gain);
      end else begin
        send_beat(row.func, row.addr, row.value, row.mix, row.chk, row.want);
      end
    end

    // random phases, each from phase zero with small steps either way
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      send_beat(FUNC_STOP, '0, '0, '0, 1'b0, '0);
      settle();
      case ($urandom_range(0, 5))
        0: inc = '0;
        1: inc = INC_ONE;
        2: inc = INC_MAX;
        3: inc = INC_BITS'($urandom_range(1, 1 << 16));
        default: inc = INC_MAX - INC_BITS'($urandom_range(0, 1 << 16));
      endcase
      case ($urandom_range(0, 4))
        0: gain = '0;
        1: gain = LEVEL_RESET;
        2: gain = GAIN_MAX;
        default: gain = GAIN_BITS'($urandom);
      endcase
      load_regs(inc, gain);
      no_idle = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) f = FUNC_TICK;
        else if (pick < 90) f = FUNC_WRITE;
        else if (pick < 93) f = FUNC_STOP;
        else f = FUNC_UNUSED;
        send_beat(f, TABLE_ADDR_BITS'($urandom), rand_sample(), rand_sample(), 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    settle();
    if (errors == 0)
      $display("wavetable_oscillator_lerp regression: pass");
    else
      $display("wavetable_oscillator_lerp regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
